@@ hw/rtl/rchue_pkg.sv @@
`default_nettype none

package rchue_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_ON_THRESHOLD     = 3'd0,
    CFG_HUE_PULSE_MIN    = 3'd1,
    CFG_HUE_PULSE_MAX    = 3'd2,
    CFG_BRIGHT_PULSE_MIN = 3'd3,
    CFG_BRIGHT_PULSE_MAX = 3'd4
  } cfg_idx_e;

  localparam int unsigned CfgWidth  = 16;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned QuotW     = 9;
  localparam int unsigned WidthInit = 1500;

  localparam logic [15:0] OnThresholdInit    = 16'd1800;
  localparam logic [15:0] HuePulseMinInit    = 16'd1000;
  localparam logic [15:0] HuePulseMaxInit    = 16'd2000;
  localparam logic [15:0] BrightPulseMinInit = 16'd1200;
  localparam logic [15:0] BrightPulseMaxInit = 16'd1800;

  localparam logic [8:0]  HueTop    = 9'd360;
  localparam logic [8:0]  DutyTop   = 9'd255;
  localparam logic [7:0]  DutyFull  = 8'd255;
  localparam logic [5:0]  SectorDeg = 6'd60;
  // ceil(2^16 / 60), exact for hues up to 360
  localparam logic [10:0] SectorRecip = 11'd1093;

  // dominant color codes
  localparam logic [1:0] DOM_NONE  = 2'd0;
  localparam logic [1:0] DOM_BLUE  = 2'd1;
  localparam logic [1:0] DOM_GREEN = 2'd2;
  localparam logic [1:0] DOM_RED   = 2'd3;

  // micro-operations
  typedef enum logic [3:0] {
    OP_WAIT,
    OP_CHECK,
    OP_LOAD,
    OP_PRE,
    OP_ITER,
    OP_STORE,
    OP_SECTOR,
    OP_RGB,
    OP_EMIT,
    OP_JUMP
  } op_e;

  typedef logic [3:0] step_t;

  localparam step_t STEP_WAIT      = 4'd0;
  localparam step_t STEP_CHECK     = 4'd1;
  localparam step_t STEP_HUE_LOAD  = 4'd2;
  localparam step_t STEP_HUE_PRE   = 4'd3;
  localparam step_t STEP_HUE_ITER  = 4'd4;
  localparam step_t STEP_HUE_STORE = 4'd5;
  localparam step_t STEP_BRT_LOAD  = 4'd6;
  localparam step_t STEP_BRT_PRE   = 4'd7;
  localparam step_t STEP_BRT_ITER  = 4'd8;
  localparam step_t STEP_BRT_STORE = 4'd9;
  localparam step_t STEP_SECTOR    = 4'd10;
  localparam step_t STEP_RGB       = 4'd11;
  localparam step_t STEP_EMIT      = 4'd12;

  // mapping select: hue or brightness
  localparam logic SEL_HUE    = 1'b0;
  localparam logic SEL_BRIGHT = 1'b1;

  typedef struct packed {
    op_e   op;
    logic  sel;
    step_t target;
  } uword_t;

  // control of the mapping divider
  typedef struct packed {
    logic load;
    logic pre;
    logic iter;
  } map_ctrl_t;

  // status of the mapping divider
  typedef struct packed {
    logic resolved;
    logic last;
  } map_stat_t;

  // microcode program
  function automatic uword_t ucode(input step_t step);
    uword_t w;
    case (step)
      STEP_WAIT:      w = '{op: OP_WAIT,   sel: SEL_HUE,    target: STEP_CHECK};
      STEP_CHECK:     w = '{op: OP_CHECK,  sel: SEL_HUE,    target: STEP_EMIT};
      STEP_HUE_LOAD:  w = '{op: OP_LOAD,   sel: SEL_HUE,    target: STEP_HUE_PRE};
      STEP_HUE_PRE:   w = '{op: OP_PRE,    sel: SEL_HUE,    target: STEP_HUE_STORE};
      STEP_HUE_ITER:  w = '{op: OP_ITER,   sel: SEL_HUE,    target: STEP_HUE_ITER};
      STEP_HUE_STORE: w = '{op: OP_STORE,  sel: SEL_HUE,    target: STEP_BRT_LOAD};
      STEP_BRT_LOAD:  w = '{op: OP_LOAD,   sel: SEL_BRIGHT, target: STEP_BRT_PRE};
      STEP_BRT_PRE:   w = '{op: OP_PRE,    sel: SEL_BRIGHT, target: STEP_BRT_STORE};
      STEP_BRT_ITER:  w = '{op: OP_ITER,   sel: SEL_BRIGHT, target: STEP_BRT_ITER};
      STEP_BRT_STORE: w = '{op: OP_STORE,  sel: SEL_BRIGHT, target: STEP_SECTOR};
      STEP_SECTOR:    w = '{op: OP_SECTOR, sel: SEL_HUE,    target: STEP_RGB};
      STEP_RGB:       w = '{op: OP_RGB,    sel: SEL_HUE,    target: STEP_EMIT};
      STEP_EMIT:      w = '{op: OP_EMIT,   sel: SEL_HUE,    target: STEP_WAIT};
      default:        w = '{op: OP_JUMP,   sel: SEL_HUE,    target: STEP_WAIT};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/rchue_map_div.sv @@
`default_nettype none

// maps a pulse width to (w - lo) * top / (hi - lo) in 0..511, one quotient bit per step
module rchue_map_div #(
  parameter int unsigned CW = 16
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  rchue_pkg::map_ctrl_t           ctrl_i,
  input  wire [CW-1:0]                   width_i,
  input  wire [15:0]                     lo_i,
  input  wire [15:0]                     hi_i,
  input  wire [8:0]                      top_i,
  output rchue_pkg::map_stat_t           stat_o,
  output logic [rchue_pkg::QuotW-1:0]    quot_o
);
  import rchue_pkg::*;

  localparam int unsigned NW = CW + 10;

  logic [CW:0]      diff;
  logic             diff_neg;
  logic [CW:0]      diff_mag;
  logic [16:0]      span;
  logic             span_neg;
  logic [15:0]      span_mag;
  logic [NW-1:0]    num;

  logic [NW-1:0]    num_q;
  logic [15:0]      smag_q;
  logic             zero_q;
  logic             neg_q;
  logic [15:0]      rem_q;
  logic [8:0]       bits_q;
  logic [3:0]       cnt_q;
  logic [QuotW-1:0] quot_q;

  logic             sat;
  logic [16:0]      trial;
  logic             ge;

  // operand setup: magnitudes and signs
  always_comb begin
    diff     = {1'b0, width_i} - (CW+1)'(lo_i);
    diff_neg = diff[CW];
    diff_mag = diff_neg ? (~diff + 1'b1) : diff;
    span     = {1'b0, hi_i} - {1'b0, lo_i};
    span_neg = span[16];
    span_mag = span_neg ? 16'(~span + 1'b1) : span[15:0];
    num      = NW'(diff_mag) * NW'(top_i);
  end

  // quotient of 512 or more saturates
  assign sat   = num_q[NW-1:9] >= (CW+1)'(smag_q);
  assign trial = {rem_q, bits_q[8]};
  assign ge    = trial >= {1'b0, smag_q};

  assign stat_o.resolved = zero_q || neg_q || sat;
  assign stat_o.last     = (cnt_q == 4'd0);
  assign quot_o          = quot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= 4'd0;
      zero_q <= 1'b0;
      neg_q  <= 1'b0;
    end else begin
      // latch operands
      if (ctrl_i.load) begin
        num_q  <= num;
        smag_q <= span_mag;
        zero_q <= (span_mag == 16'd0);
        neg_q  <= diff_neg ^ span_neg;
      end
      // resolve special cases or start the long division
      if (ctrl_i.pre) begin
        if (zero_q || neg_q) begin
          quot_q <= '0;
        end else if (sat) begin
          quot_q <= '1;
        end else begin
          quot_q <= '0;
          rem_q  <= num_q[24:9];
          bits_q <= num_q[8:0];
          cnt_q  <= 4'd8;
        end
      end
      // one restoring step
      if (ctrl_i.iter) begin
        rem_q  <= ge ? 16'(trial - {1'b0, smag_q}) : trial[15:0];
        quot_q <= {quot_q[QuotW-2:0], ge};
        bits_q <= {bits_q[7:0], 1'b0};
        cnt_q  <= cnt_q - 4'd1;
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/rc_pulse_to_hue_led_driver.sv @@
// RC pulse decoder driving a hue LED and mono LEDs.
// Input channel: one item per microsecond tick, three sampled receiver pin
// levels. Each channel counts its high time (saturating) and latches the
// width on a falling edge; the result uses the widths as updated by the tick.
// Output channel: one item per input item with RGB duties, mono duty, enable
// and dominant color; all zero when the on/off width is below on_threshold.
// Configuration: write enable, index and 16-bit data, taken at any edge with
// the enable high; unknown indexes are ignored.
// Sequencing: a microcoded sequencer steps through a 13-word program; the
// two mappings share one divider that yields one quotient bit per cycle.
// An enabled item runs check, then load, pre, iterations and store for each
// mapping, then sector, rgb and emit; a mapping that clamps to zero,
// overflows nine quotient bits or hits a zero span skips its iterations;
// a disabled item goes from check straight to emit. The next item is
// accepted only in the wait step after emit, not while one is in progress.
// Stall: the result sits in an output register; while it waits, the block
// accepts and works on the next item and holds in its emit step until free.
// Reset: widths return to 1500, counters and levels to zero, registers to
// their defaults, and no result is pending.
`default_nettype none

module rc_pulse_to_hue_led_driver #(
  parameter int unsigned PULSE_COUNT_BITS = 16
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           cfg_we_i,
  input  wire [rchue_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire [rchue_pkg::CfgWidth-1:0] cfg_wdata_i,
  input  wire                           in_valid_i,
  output logic                          in_ready_o,
  input  wire                           on_off_level_i,
  input  wire                           hue_level_i,
  input  wire                           brightness_level_i,
  output logic                          out_valid_o,
  input  wire                           out_ready_i,
  output logic [7:0]                    red_duty_o,
  output logic [7:0]                    green_duty_o,
  output logic [7:0]                    blue_duty_o,
  output logic [7:0]                    mono_duty_o,
  output logic                          leds_enabled_o,
  output logic [1:0]                    dominant_color_o
);
  import rchue_pkg::*;

  localparam int unsigned W  = PULSE_COUNT_BITS;
  localparam int unsigned CW = (W > 16) ? W : 16;
  localparam int unsigned NCh = 3;

  // config registers
  logic [15:0] on_thr_q, hue_min_q, hue_max_q, brt_min_q, brt_max_q;

  // channel timing
  logic [NCh-1:0] prev_q;
  logic [W-1:0]   cnt_q   [NCh];
  logic [W-1:0]   width_q [NCh];
  logic [NCh-1:0] lvl;

  // sequencer and datapath
  step_t          step_q, step_d;
  uword_t         uw;
  map_ctrl_t      mctrl;
  map_stat_t      mstat;
  logic [QuotW-1:0] quot;
  logic           en_q;
  logic [8:0]     hue_q;
  logic [7:0]     mono_q;
  logic [2:0]     sec_q;
  logic [5:0]     t_q;
  logic [7:0]     red_q, green_q, blue_q;

  logic           accept;
  logic           out_free;
  logic           enable_now;
  logic [CW-1:0]  map_w;
  logic [15:0]    map_lo, map_hi;
  logic [8:0]     map_top;
  logic [19:0]    sec_prod;
  logic [2:0]     sec;
  logic [8:0]     t_full;
  logic [9:0]     rise17, fall17;
  logic [7:0]     ramp;
  logic [2:0]     sec_sel;
  logic [1:0]     dom;

  assign lvl        = {brightness_level_i, hue_level_i, on_off_level_i};
  assign uw         = ucode(step_q);
  assign in_ready_o = (uw.op == OP_WAIT);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_o || out_ready_i;
  assign enable_now = CW'(width_q[0]) >= CW'(on_thr_q);

  // next step
  always_comb begin
    step_d = step_q + 4'd1;
    case (uw.op)
      OP_WAIT:  if (!accept) step_d = step_q;
      OP_CHECK: if (!enable_now) step_d = uw.target;
      OP_PRE:   if (mstat.resolved) step_d = uw.target;
      OP_ITER:  if (!mstat.last) step_d = uw.target;
      OP_EMIT:  step_d = out_free ? uw.target : step_q;
      OP_JUMP:  step_d = uw.target;
      default:  step_d = step_q + 4'd1;
    endcase
  end

  // divider operands
  always_comb begin
    mctrl.load = (uw.op == OP_LOAD);
    mctrl.pre  = (uw.op == OP_PRE);
    mctrl.iter = (uw.op == OP_ITER);
    if (uw.sel == SEL_BRIGHT) begin
      map_w   = CW'(width_q[2]);
      map_lo  = brt_min_q;
      map_hi  = brt_max_q;
      map_top = DutyTop;
    end else begin
      map_w   = CW'(width_q[1]);
      map_lo  = hue_min_q;
      map_hi  = hue_max_q;
      map_top = HueTop;
    end
  end

  rchue_map_div #(
    .CW(CW)
  ) u_map_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (mctrl),
    .width_i (map_w),
    .lo_i    (map_lo),
    .hi_i    (map_hi),
    .top_i   (map_top),
    .stat_o  (mstat),
    .quot_o  (quot)
  );

  // hue sector and remainder by reciprocal multiply
  always_comb begin
    sec_prod = 20'(hue_q) * 20'(SectorRecip);
    sec      = sec_prod[18:16];
    t_full   = hue_q - 9'(sec) * 9'(SectorDeg);
  end

  // ramps: 255*t/60 is 17*t/4
  always_comb begin
    rise17  = 10'(t_q) * 10'd17;
    fall17  = 10'(SectorDeg - t_q) * 10'd17;
    ramp    = sec_q[0] ? fall17[9:2] : rise17[9:2];
    sec_sel = (sec_q > 3'd5) ? 3'd5 : sec_q;
  end

  // dominant color
  always_comb begin
    if (red_q > green_q && red_q > blue_q) begin
      dom = DOM_RED;
    end else if (green_q > red_q && green_q > blue_q) begin
      dom = DOM_GREEN;
    end else if (blue_q > red_q && blue_q > green_q) begin
      dom = DOM_BLUE;
    end else begin
      dom = DOM_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= STEP_WAIT;
      on_thr_q    <= OnThresholdInit;
      hue_min_q   <= HuePulseMinInit;
      hue_max_q   <= HuePulseMaxInit;
      brt_min_q   <= BrightPulseMinInit;
      brt_max_q   <= BrightPulseMaxInit;
      prev_q      <= '0;
      for (int i = 0; i < NCh; i++) begin
        cnt_q[i]   <= '0;
        width_q[i] <= W'(WidthInit);
      end
      en_q        <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      step_q <= step_d;

      // configuration writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ON_THRESHOLD:     on_thr_q  <= cfg_wdata_i;
          CFG_HUE_PULSE_MIN:    hue_min_q <= cfg_wdata_i;
          CFG_HUE_PULSE_MAX:    hue_max_q <= cfg_wdata_i;
          CFG_BRIGHT_PULSE_MIN: brt_min_q <= cfg_wdata_i;
          CFG_BRIGHT_PULSE_MAX: brt_max_q <= cfg_wdata_i;
          default: ;
        endcase
      end

      // pulse timing on each accepted tick
      if (accept) begin
        prev_q <= lvl;
        for (int i = 0; i < NCh; i++) begin
          if (lvl[i]) begin
            if (!prev_q[i]) begin
              cnt_q[i] <= W'(1);
            end else if (cnt_q[i] != '1) begin
              cnt_q[i] <= cnt_q[i] + W'(1);
            end
          end else if (prev_q[i]) begin
            width_q[i] <= cnt_q[i];
          end
        end
      end

      if (uw.op == OP_CHECK) begin
        en_q <= enable_now;
      end

      // clamp and store mapped values
      if (uw.op == OP_STORE) begin
        if (uw.sel == SEL_BRIGHT) begin
          mono_q <= (quot > DutyTop) ? DutyFull : quot[7:0];
        end else begin
          hue_q <= (quot > HueTop) ? HueTop : quot;
        end
      end

      if (uw.op == OP_SECTOR) begin
        sec_q <= sec;
        t_q   <= t_full[5:0];
      end

      // full-saturation hue to rgb
      if (uw.op == OP_RGB) begin
        case (sec_sel)
          3'd0: begin red_q <= DutyFull; green_q <= ramp;     blue_q <= 8'd0;     end
          3'd1: begin red_q <= ramp;     green_q <= DutyFull; blue_q <= 8'd0;     end
          3'd2: begin red_q <= 8'd0;     green_q <= DutyFull; blue_q <= ramp;     end
          3'd3: begin red_q <= 8'd0;     green_q <= ramp;     blue_q <= DutyFull; end
          3'd4: begin red_q <= ramp;     green_q <= 8'd0;     blue_q <= DutyFull; end
          default: begin red_q <= DutyFull; green_q <= 8'd0;  blue_q <= ramp;     end
        endcase
      end

      // output register
      if (uw.op == OP_EMIT && out_free) begin
        out_valid_o      <= 1'b1;
        red_duty_o       <= en_q ? red_q : 8'd0;
        green_duty_o     <= en_q ? green_q : 8'd0;
        blue_duty_o      <= en_q ? blue_q : 8'd0;
        mono_duty_o      <= en_q ? mono_q : 8'd0;
        leds_enabled_o   <= en_q;
        dominant_color_o <= en_q ? dom : DOM_NONE;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rchue_pkg::*;

  localparam int unsigned PULSE_BITS   = 16;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 32;
  localparam int unsigned END_WAIT     = 4000;
  localparam int unsigned MAX_PRINTED  = 40;

  localparam logic [PULSE_BITS-1:0] COUNT_CEILING = '1;

  localparam int CH_ON_OFF = 0;
  localparam int CH_HUE    = 1;
  localparam int CH_BRIGHT = 2;

  localparam longint HUE_FULL   = 360;
  localparam longint DUTY_FULL  = 255;
  localparam longint SECTOR_LEN = 60;

  // register indexes with no register behind them
  localparam logic [CfgIdxW-1:0] CFG_IDX_SPARE_LO = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_IDX_SPARE_HI = 3'd7;

  typedef struct packed {
    logic on_off;
    logic hue;
    logic bright;
    logic drain;  // hold the item back until every frame has come back
    logic rush;   // no idling on either side while this item is out
  } tick_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] mono;
    logic       enabled;
    logic [1:0] dominant;
  } led_frame_t;

  logic                clk_i              = 1'b0;
  logic                rst_ni             = 1'b0;
  logic                cfg_we_i           = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i          = '0;
  logic [CfgWidth-1:0] cfg_wdata_i        = '0;
  logic                in_valid_i         = 1'b0;
  logic                on_off_level_i     = 1'b0;
  logic                hue_level_i        = 1'b0;
  logic                brightness_level_i = 1'b0;
  logic                out_ready_i        = 1'b0;
  logic                in_ready_o;
  logic                out_valid_o;
  logic [7:0]          red_duty_o;
  logic [7:0]          green_duty_o;
  logic [7:0]          blue_duty_o;
  logic [7:0]          mono_duty_o;
  logic                leds_enabled_o;
  logic [1:0]          dominant_color_o;

  rc_pulse_to_hue_led_driver #(
    .PULSE_COUNT_BITS(PULSE_BITS)
  ) u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .on_off_level_i     (on_off_level_i),
    .hue_level_i        (hue_level_i),
    .brightness_level_i (brightness_level_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .red_duty_o         (red_duty_o),
    .green_duty_o       (green_duty_o),
    .blue_duty_o        (blue_duty_o),
    .mono_duty_o        (mono_duty_o),
    .leds_enabled_o     (leds_enabled_o),
    .dominant_color_o   (dominant_color_o)
  );

  // decoder copy: registers, pin history, counters and latched widths
  logic [15:0]           reg_thr;
  logic [15:0]           reg_hue_lo;
  logic [15:0]           reg_hue_hi;
  logic [15:0]           reg_brt_lo;
  logic [15:0]           reg_brt_hi;
  logic [2:0]            prev_lv;
  logic [PULSE_BITS-1:0] high_cnt [3];
  logic [PULSE_BITS-1:0] pulse_w  [3];

  tick_t       ticks_to_send [$];
  led_frame_t  led_frames_due [$];
  tick_t       cur_tick;
  logic        rush = 1'b0;
  int unsigned send_gap    = 0;
  int unsigned send_burst  = 0;
  int unsigned stall_left  = 0;
  int unsigned recv_burst  = 0;
  int unsigned error_count = 0;
  int unsigned frame_count = 0;
  int unsigned cycle_count = 0;
  logic        train_lv   [3];
  int unsigned train_left [3];

  initial begin : clock_gen
    forever #6 clk_i = ~clk_i;
  end

  task automatic flag_mismatch(input string what, input int got, input int want);
    if (error_count < MAX_PRINTED) begin
      $display("[%0t] frame %0d: %s got %0d want %0d", $time, frame_count, what, got, want);
    end
    error_count++;
  endtask

  // width to output scale, truncated toward zero and clamped to 0..top
  function automatic longint scale_width(input logic [15:0] w, input logic [15:0] lo,
                                         input logic [15:0] hi, input longint top);
    longint span;
    longint v;
    span = longint'(hi) - longint'(lo);
    if (span == 0) return 0;
    v = ((longint'(w) - longint'(lo)) * top) / span;
    if (v < 0) v = 0;
    if (v > top) v = top;
    return v;
  endfunction

  // full saturation hue wheel, six sectors of 60 degrees
  function automatic led_frame_t hue_color(input longint h);
    led_frame_t f;
    longint     q;
    longint     t;
    longint     ramp;
    f = '0;
    q = h / SECTOR_LEN;
    t = h % SECTOR_LEN;
    if (q % 2 == 0) ramp = (DUTY_FULL * t) / SECTOR_LEN;
    else ramp = (DUTY_FULL * (SECTOR_LEN - t)) / SECTOR_LEN;
    if (q > 5) q = 5;
    case (q)
      0: begin
        f.red = 8'hFF; f.green = ramp[7:0];
      end
      1: begin
        f.red = ramp[7:0]; f.green = 8'hFF;
      end
      2: begin
        f.green = 8'hFF; f.blue = ramp[7:0];
      end
      3: begin
        f.green = ramp[7:0]; f.blue = 8'hFF;
      end
      4: begin
        f.red = ramp[7:0]; f.blue = 8'hFF;
      end
      default: begin
        f.red = 8'hFF; f.blue = ramp[7:0];
      end
    endcase
    return f;
  endfunction

  // one microsecond tick: update pulse timing, then derive the led frame
  function automatic led_frame_t advance_decoder(input tick_t tk);
    logic [2:0] now;
    longint     hue;
    longint     mono;
    led_frame_t f;
    now = {tk.bright, tk.hue, tk.on_off};
    for (int c = 0; c < 3; c++) begin
      if (now[c]) begin
        if (!prev_lv[c]) high_cnt[c] = PULSE_BITS'(1);
        else if (high_cnt[c] != COUNT_CEILING) high_cnt[c] = high_cnt[c] + 1'b1;
      end else if (prev_lv[c]) begin
        pulse_w[c] = high_cnt[c];
      end
    end
    prev_lv = now;
    f = '0;
    if (pulse_w[CH_ON_OFF] >= reg_thr) begin
      hue = scale_width(pulse_w[CH_HUE], reg_hue_lo, reg_hue_hi, HUE_FULL);
      f = hue_color(hue);
      mono = scale_width(pulse_w[CH_BRIGHT], reg_brt_lo, reg_brt_hi, DUTY_FULL);
      f.mono = mono[7:0];
      f.enabled = 1'b1;
      if (f.red > f.green && f.red > f.blue) f.dominant = DOM_RED;
      else if (f.green > f.red && f.green > f.blue) f.dominant = DOM_GREEN;
      else if (f.blue > f.red && f.blue > f.green) f.dominant = DOM_BLUE;
      else f.dominant = DOM_NONE;
    end
    return f;
  endfunction

  // idle length: mostly none or short, a few long, with idle-free bursts
  function automatic int unsigned pick_idle(inout int unsigned burst);
    int unsigned r;
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 49) == 0) begin
      burst = $urandom_range(20, 100);
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  // tick driver: presents queued items, predicts each one at acceptance
  always @(posedge clk_i) begin : tick_driver
    logic  slot_free;
    tick_t nxt;
    if (rst_ni) begin
      slot_free = !in_valid_i;
      if (in_valid_i && in_ready_o) begin
        led_frames_due.push_back(advance_decoder(cur_tick));
        slot_free = 1'b1;
      end
      if (slot_free) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (ticks_to_send.size() != 0 &&
                     !(ticks_to_send[0].drain && led_frames_due.size() != 0)) begin
          nxt = ticks_to_send.pop_front();
          cur_tick = nxt;
          rush = nxt.rush;
          in_valid_i         <= 1'b1;
          on_off_level_i     <= nxt.on_off;
          hue_level_i        <= nxt.hue;
          brightness_level_i <= nxt.bright;
          send_gap = nxt.rush ? 0 : pick_idle(send_burst);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // frame monitor: compares each accepted frame with the oldest prediction
  always @(posedge clk_i) begin : frame_monitor
    led_frame_t seen;
    led_frame_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        seen = '{red: red_duty_o, green: green_duty_o, blue: blue_duty_o,
                 mono: mono_duty_o, enabled: leds_enabled_o,
                 dominant: dominant_color_o};
        if (led_frames_due.size() == 0) begin
          flag_mismatch("frame with nothing expected, red", seen.red, 0);
        end else begin
          want = led_frames_due.pop_front();
          if (seen.red != want.red) flag_mismatch("red_duty", seen.red, want.red);
          if (seen.green != want.green) flag_mismatch("green_duty", seen.green, want.green);
          if (seen.blue != want.blue) flag_mismatch("blue_duty", seen.blue, want.blue);
          if (seen.mono != want.mono) flag_mismatch("mono_duty", seen.mono, want.mono);
          if (seen.enabled != want.enabled) begin
            flag_mismatch("leds_enabled", seen.enabled, want.enabled);
          end
          if (seen.dominant != want.dominant) begin
            flag_mismatch("dominant_color", seen.dominant, want.dominant);
          end
        end
        frame_count++;
      end
      if (rush) begin
        stall_left = 0;
        out_ready_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (out_valid_o && out_ready_i) stall_left = pick_idle(recv_burst);
      end
    end
  end

  // register write, applied to the decoder copy at the same time
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CFG_ON_THRESHOLD:     reg_thr = val;
      CFG_HUE_PULSE_MIN:    reg_hue_lo = val;
      CFG_HUE_PULSE_MAX:    reg_hue_hi = val;
      CFG_BRIGHT_PULSE_MIN: reg_brt_lo = val;
      CFG_BRIGHT_PULSE_MAX: reg_brt_hi = val;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_config(input logic [15:0] thr, input logic [15:0] hlo,
                            input logic [15:0] hhi, input logic [15:0] blo,
                            input logic [15:0] bhi);
    write_reg(CFG_ON_THRESHOLD, thr);
    write_reg(CFG_HUE_PULSE_MIN, hlo);
    write_reg(CFG_HUE_PULSE_MAX, hhi);
    write_reg(CFG_BRIGHT_PULSE_MIN, blo);
    write_reg(CFG_BRIGHT_PULSE_MAX, bhi);
  endtask

  // block until every item went out and every frame came back
  task automatic wait_drained();
    do @(negedge clk_i);
    while (ticks_to_send.size() != 0 || in_valid_i || led_frames_due.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic queue_hold(input logic on, input logic hue, input logic brt,
                            input int unsigned n, input logic fast);
    repeat (n) begin
      ticks_to_send.push_back('{on_off: on, hue: hue, bright: brt, drain: 1'b0, rush: fast});
    end
  endtask

  // independent pulse trains per channel, with stretches of random noise
  task automatic queue_train(input int unsigned n, input int unsigned cap_on,
                             input int unsigned cap_hue, input int unsigned cap_brt);
    int unsigned caps [3];
    int unsigned noise_left;
    logic        lv [3];
    caps[CH_ON_OFF] = cap_on;
    caps[CH_HUE]    = cap_hue;
    caps[CH_BRIGHT] = cap_brt;
    noise_left = 0;
    repeat (n) begin
      if (noise_left == 0 && $urandom_range(0, 29) == 0) noise_left = $urandom_range(3, 15);
      for (int c = 0; c < 3; c++) begin
        if (noise_left > 0) begin
          lv[c] = ($urandom_range(0, 1) != 0);
        end else begin
          if (train_left[c] == 0) begin
            train_lv[c] = !train_lv[c];
            if (!train_lv[c]) train_left[c] = $urandom_range(1, 5);
            else if ($urandom_range(0, 9) == 0) train_left[c] = 1;
            else train_left[c] = $urandom_range(1, caps[c] + 3);
          end
          train_left[c]--;
          lv[c] = train_lv[c];
        end
      end
      if (noise_left > 0) noise_left--;
      ticks_to_send.push_back('{on_off: lv[CH_ON_OFF], hue: lv[CH_HUE],
                                bright: lv[CH_BRIGHT],
                                drain: ($urandom_range(0, 199) == 0), rush: 1'b0});
    end
  endtask

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : main_seq
    int unsigned thr;
    int unsigned hlo;
    int unsigned hhi;
    int unsigned blo;
    int unsigned bhi;
    int unsigned settle;
    led_frame_t  lost;

    // decoder copy at reset
    reg_thr    = OnThresholdInit;
    reg_hue_lo = HuePulseMinInit;
    reg_hue_hi = HuePulseMaxInit;
    reg_brt_lo = BrightPulseMinInit;
    reg_brt_hi = BrightPulseMaxInit;
    prev_lv    = '0;
    for (int c = 0; c < 3; c++) begin
      high_cnt[c]   = '0;
      pulse_w[c]    = PULSE_BITS'(WidthInit);
      train_lv[c]   = 1'b0;
      train_left[c] = 0;
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // writes to unused indexes must not land anywhere
    write_reg(CFG_IDX_SPARE_LO, 16'h0000);
    write_reg(CFG_IDX_SPARE_HI, 16'hFFFF);

    // reset widths are below the default threshold
    queue_hold(1'b0, 1'b0, 1'b0, 2, 1'b0);
    wait_drained();

    // threshold just above, then equal to the reset widths, default ranges
    write_reg(CFG_ON_THRESHOLD, 16'd1501);
    queue_hold(1'b0, 1'b0, 1'b0, 2, 1'b0);
    wait_drained();
    write_reg(CFG_ON_THRESHOLD, 16'd1500);
    queue_hold(1'b0, 1'b0, 1'b0, 3, 1'b0);
    wait_drained();

    // sweep the hue over every sector boundary and past the top
    set_config(16'd2, 16'd1, 16'd13, 16'd1, 16'd6);
    queue_hold(1'b1, 1'b0, 1'b0, 3, 1'b0);
    queue_hold(1'b0, 1'b0, 1'b0, 1, 1'b0);
    for (int w = 1; w <= 15; w += 2) begin
      queue_hold(1'b0, 1'b1, 1'b1, w, 1'b0);
      queue_hold(1'b0, 1'b0, 1'b0, 1, 1'b0);
    end
    wait_drained();

    // normal small ranges
    set_config(16'd4, 16'd2, 16'd26, 16'd1, 16'd16);
    queue_train(250, 8, 28, 18);
    wait_drained();

    // reversed ranges, always enabled
    set_config(16'd0, 16'd30, 16'd3, 16'd20, 16'd2);
    queue_train(200, 4, 32, 22);
    wait_drained();

    // zero spans
    set_config(16'd1, 16'd10, 16'd10, 16'd7, 16'd7);
    queue_train(150, 4, 14, 10);
    wait_drained();

    // widest and widest reversed ranges
    set_config(16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0);
    queue_train(150, 4, 20, 20);
    wait_drained();

    // threshold that short on/off pulses miss
    set_config(16'd12, 16'd5, 16'd17, 16'd3, 16'd40);
    queue_train(200, 16, 20, 44);
    wait_drained();

    // random small settings
    repeat (3) begin
      thr = $urandom_range(0, 15);
      hlo = $urandom_range(0, 40);
      hhi = $urandom_range(0, 40);
      blo = $urandom_range(0, 40);
      bhi = $urandom_range(0, 40);
      set_config(16'(thr), 16'(hlo), 16'(hhi), 16'(blo), 16'(bhi));
      queue_train(150, thr + 4, (hlo > hhi ? hlo : hhi) + 4, (blo > bhi ? blo : bhi) + 4);
      wait_drained();
    end

    // wind down: everything sent, then give the frames time to arrive
    while (ticks_to_send.size() != 0 || in_valid_i) @(negedge clk_i);
    settle = 0;
    while (led_frames_due.size() != 0 && settle < END_WAIT) begin
      @(negedge clk_i);
      settle++;
    end
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    while (led_frames_due.size() != 0) begin
      lost = led_frames_due.pop_front();
      flag_mismatch("frame never arrived, red", 0, lost.red);
    end

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
